[hw/rtl/hitf_pkg.sv]
// Shared types, constants and helper functions of the IPv4 TCP/UDP header filter.
package hitf_pkg;

    // Default frame length limit: bytes at or past it are not examined.
    localparam int unsigned MAX_FRAME_BYTES_DEF = 16383;

    // Depth of the queue between the parser and the verdict stage.
    localparam int unsigned FIFO_DEPTH = 4;

    // Configuration register indexes.
    localparam logic [2:0] REG_MATCH_ENABLES = 3'd0;
    localparam logic [2:0] REG_SRC_MAC       = 3'd1;
    localparam logic [2:0] REG_DST_MAC       = 3'd2;
    localparam logic [2:0] REG_SRC_IP        = 3'd3;
    localparam logic [2:0] REG_DST_IP        = 3'd4;
    localparam logic [2:0] REG_PROTOCOL      = 3'd5;
    localparam logic [2:0] REG_SRC_PORT      = 3'd6;
    localparam logic [2:0] REG_DST_PORT      = 3'd7;

    // Protocol constants.
    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_TCP      = 8'd6;
    localparam logic [7:0]  PROTO_UDP      = 8'd17;

    // Byte offsets within the frame.
    localparam int unsigned OFS_SRC_MAC   = 6;
    localparam int unsigned OFS_ETYPE     = 12;
    localparam int unsigned OFS_IHL       = 14;
    localparam int unsigned OFS_PROTOCOL  = 23;
    localparam int unsigned OFS_SRC_IP    = 26;
    localparam int unsigned OFS_DST_IP    = 30;
    localparam int unsigned OFS_IP_END    = 34;
    localparam int unsigned MIN_PORT_BYTES = 15;

    // Match enable / mismatch bit positions.
    localparam int unsigned BIT_SRC_MAC = 0;
    localparam int unsigned BIT_DST_MAC = 1;
    localparam int unsigned BIT_SRC_IP  = 2;
    localparam int unsigned BIT_DST_IP  = 3;

    // Verdict codes.
    typedef enum logic [3:0] {
        VC_OK        = 4'd0,
        VC_NOT_IPV4  = 4'd1,
        VC_SRC_MAC   = 4'd2,
        VC_DST_MAC   = 4'd3,
        VC_IP        = 4'd4,
        VC_PROTOCOL  = 4'd5,
        VC_NOT_L4    = 4'd6,
        VC_PORT      = 4'd7,
        VC_TRUNCATED = 4'd8
    } verdict_t;

    // What the parser hands to the verdict stage for one finished frame.
    typedef struct packed {
        logic        short_eth;   // fewer than 14 bytes
        logic        short_ip;    // fewer than 34 bytes
        logic        ports_in;    // all four port bytes received
        logic        is_ipv4;
        logic [3:0]  mismatch;
        logic [7:0]  protocol;
        logic [15:0] sport;
        logic [15:0] dport;
    } frame_rec_t;

    // Byte idx (0 = least significant) of a 48-bit word.
    function automatic logic [7:0] byte_of48(input logic [47:0] v, input logic [2:0] idx);
        logic [47:0] sh;
        begin
            sh = v >> {idx, 3'b000};
            return sh[7:0];
        end
    endfunction

    // Byte idx (0 = least significant) of a 32-bit word.
    function automatic logic [7:0] byte_of32(input logic [31:0] v, input logic [1:0] idx);
        logic [31:0] sh;
        begin
            sh = v >> {idx, 3'b000};
            return sh[7:0];
        end
    endfunction

endpackage

[hw/rtl/hitf_parser.sv]
// Front end: walks the frame byte by byte, captures header fields, queues a record per frame.
module hitf_parser #(
    parameter int unsigned MAX_FRAME_BYTES = hitf_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           in_byte,
    input  logic                 in_last,
    input  logic [47:0]          want_src_mac,
    input  logic [47:0]          want_dst_mac,
    input  logic [31:0]          want_src_ip,
    input  logic [31:0]          want_dst_ip,
    output logic                 rec_push,
    output hitf_pkg::frame_rec_t rec_data,
    input  logic                 rec_full
);
    localparam int unsigned POS_W = $clog2(MAX_FRAME_BYTES + 1);
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_FRAME_BYTES);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [3:0]       hw_reg, hw_next;
    logic [15:0]      etype_reg, etype_next;
    logic [7:0]       proto_reg, proto_next;
    logic [15:0]      sport_reg, sport_next;
    logic [15:0]      dport_reg, dport_next;
    logic [3:0]       mm_reg, mm_next;

    logic             accept;
    logic             examine;
    logic [2:0]       dmac_idx;
    logic [3:0]       smac_diff;
    logic [4:0]       sip_diff;
    logic [5:0]       dip_diff;
    logic [3:0]       hw_sel;
    logic [6:0]       port_ofs;
    logic [6:0]       port_end;
    logic [POS_W-1:0] src_lo;
    logic [POS_W-1:0] dst_lo;
    logic [POS_W-1:0] dst_hi;

    assign in_ready = !rec_full;
    assign accept   = in_valid && in_ready;
    assign examine  = pos_reg < POS_MAX;

    // Byte lanes of the wanted addresses that line up with the current position.
    assign dmac_idx  = 3'd5 - pos_reg[2:0];
    assign smac_diff = 4'd11 - pos_reg[3:0];
    assign sip_diff  = 5'd29 - pos_reg[4:0];
    assign dip_diff  = 6'd33 - pos_reg[5:0];

    // Ports start at 14 + 4 * IHL; that offset is never below 14. The IHL byte itself
    // already moves the port window.
    assign hw_sel   = (pos_reg == POS_W'(hitf_pkg::OFS_IHL)) ? in_byte[3:0] : hw_reg;
    assign port_ofs = 7'(hitf_pkg::OFS_IHL) + {1'b0, hw_sel, 2'b00};

    // Next per-frame state after examining the current byte.
    always_comb
    begin
        pos_next   = pos_reg;
        hw_next    = hw_reg;
        etype_next = etype_reg;
        proto_next = proto_reg;
        sport_next = sport_reg;
        dport_next = dport_reg;
        mm_next    = mm_reg;
        if (examine)
        begin
            pos_next = pos_reg + 1'b1;
            if (pos_reg < POS_W'(hitf_pkg::OFS_SRC_MAC))
            begin
                if (hitf_pkg::byte_of48(want_dst_mac, dmac_idx) != in_byte)
                    mm_next[hitf_pkg::BIT_DST_MAC] = 1'b1;
            end
            else if (pos_reg < POS_W'(hitf_pkg::OFS_ETYPE))
            begin
                if (hitf_pkg::byte_of48(want_src_mac, smac_diff[2:0]) != in_byte)
                    mm_next[hitf_pkg::BIT_SRC_MAC] = 1'b1;
            end
            else if (pos_reg < POS_W'(hitf_pkg::OFS_IHL))
            begin
                etype_next = {etype_reg[7:0], in_byte};
            end
            if (pos_reg == POS_W'(hitf_pkg::OFS_IHL))
                hw_next = in_byte[3:0];
            if (pos_reg == POS_W'(hitf_pkg::OFS_PROTOCOL))
                proto_next = in_byte;
            if (pos_reg >= POS_W'(hitf_pkg::OFS_SRC_IP) && pos_reg < POS_W'(hitf_pkg::OFS_DST_IP))
            begin
                if (hitf_pkg::byte_of32(want_src_ip, sip_diff[1:0]) != in_byte)
                    mm_next[hitf_pkg::BIT_SRC_IP] = 1'b1;
            end
            if (pos_reg >= POS_W'(hitf_pkg::OFS_DST_IP) && pos_reg < POS_W'(hitf_pkg::OFS_IP_END))
            begin
                if (hitf_pkg::byte_of32(want_dst_ip, dip_diff[1:0]) != in_byte)
                    mm_next[hitf_pkg::BIT_DST_IP] = 1'b1;
            end
            if (pos_reg >= src_lo && pos_reg < dst_lo)
                sport_next = {sport_reg[7:0], in_byte};
            else if (pos_reg >= dst_lo && pos_reg < dst_hi)
                dport_next = {dport_reg[7:0], in_byte};
        end
    end

    assign src_lo   = POS_W'(port_ofs);
    assign dst_lo   = POS_W'(port_ofs + 7'd2);
    assign dst_hi   = POS_W'(port_ofs + 7'd4);
    assign port_end = 7'(hitf_pkg::OFS_IHL + 4) + {1'b0, hw_next, 2'b00};

    // Frame summary built from the state as it stands after the last byte.
    always_comb
    begin
        rec_data.short_eth = pos_next < POS_W'(hitf_pkg::OFS_IHL);
        rec_data.short_ip  = pos_next < POS_W'(hitf_pkg::OFS_IP_END);
        rec_data.ports_in  = (pos_next >= POS_W'(hitf_pkg::MIN_PORT_BYTES))
                             && (pos_next >= POS_W'(port_end));
        rec_data.is_ipv4   = etype_next == hitf_pkg::ETHERTYPE_IPV4;
        rec_data.mismatch  = mm_next;
        rec_data.protocol  = proto_next;
        rec_data.sport     = sport_next;
        rec_data.dport     = dport_next;
    end

    assign rec_push = accept && in_last;

    // Per-frame state: advances on each word, clears after the last one.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            hw_reg    <= '0;
            etype_reg <= '0;
            proto_reg <= '0;
            sport_reg <= '0;
            dport_reg <= '0;
            mm_reg    <= '0;
        end
        else if (accept)
        begin
            if (in_last)
            begin
                pos_reg   <= '0;
                hw_reg    <= '0;
                etype_reg <= '0;
                proto_reg <= '0;
                sport_reg <= '0;
                dport_reg <= '0;
                mm_reg    <= '0;
            end
            else
            begin
                pos_reg   <= pos_next;
                hw_reg    <= hw_next;
                etype_reg <= etype_next;
                proto_reg <= proto_next;
                sport_reg <= sport_next;
                dport_reg <= dport_next;
                mm_reg    <= mm_next;
            end
        end
    end

endmodule

[hw/rtl/hitf_fifo.sv]
// Short record queue between the parser and the verdict stage.
module hitf_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  hitf_pkg::frame_rec_t push_data,
    output logic                 full,
    input  logic                 pop,
    output hitf_pkg::frame_rec_t pop_data,
    output logic                 empty
);
    localparam int unsigned AW = $clog2(hitf_pkg::FIFO_DEPTH);
    localparam int unsigned CW = $clog2(hitf_pkg::FIFO_DEPTH + 1);

    hitf_pkg::frame_rec_t mem [hitf_pkg::FIFO_DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_push;
    logic          do_pop;

    assign full     = count_reg == CW'(hitf_pkg::FIFO_DEPTH);
    assign empty    = count_reg == '0;
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem[rd_ptr_reg];

    // Storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_data;
    end

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == AW'(hitf_pkg::FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == AW'(hitf_pkg::FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

[hw/rtl/hitf_verdict.sv]
// Back end: turns a frame record into the verdict word and holds it in the output register.
module hitf_verdict (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 rec_empty,
    input  hitf_pkg::frame_rec_t rec_data,
    output logic                 rec_pop,
    input  logic [3:0]           match_enables,
    input  logic [7:0]           want_protocol,
    input  logic [15:0]          want_src_port,
    input  logic [15:0]          want_dst_port,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [47:0]          out_data
);
    hitf_pkg::verdict_t verdict;
    logic               valid_reg;
    logic [47:0]        data_reg;
    logic               load;
    logic [3:0]         en_mm;
    logic               port_bad;
    logic [15:0]        sport_out;
    logic [15:0]        dport_out;

    assign en_mm    = match_enables & rec_data.mismatch;
    assign port_bad = (want_src_port != '0 && want_src_port != rec_data.sport)
                      || (want_dst_port != '0 && want_dst_port != rec_data.dport);

    // First failing check, in priority order.
    always_comb
    begin
        priority if (rec_data.short_eth)
            verdict = hitf_pkg::VC_TRUNCATED;
        else if (!rec_data.is_ipv4)
            verdict = hitf_pkg::VC_NOT_IPV4;
        else if (en_mm[hitf_pkg::BIT_SRC_MAC])
            verdict = hitf_pkg::VC_SRC_MAC;
        else if (en_mm[hitf_pkg::BIT_DST_MAC])
            verdict = hitf_pkg::VC_DST_MAC;
        else if (rec_data.short_ip)
            verdict = hitf_pkg::VC_TRUNCATED;
        else if (en_mm[hitf_pkg::BIT_SRC_IP] || en_mm[hitf_pkg::BIT_DST_IP])
            verdict = hitf_pkg::VC_IP;
        else if (want_protocol != '0 && want_protocol != rec_data.protocol)
            verdict = hitf_pkg::VC_PROTOCOL;
        else if (rec_data.protocol != hitf_pkg::PROTO_TCP
                 && rec_data.protocol != hitf_pkg::PROTO_UDP)
            verdict = hitf_pkg::VC_NOT_L4;
        else if (!rec_data.ports_in)
            verdict = hitf_pkg::VC_TRUNCATED;
        else if (port_bad)
            verdict = hitf_pkg::VC_PORT;
        else
            verdict = hitf_pkg::VC_OK;
    end

    // Ports are reported only when all four bytes arrived.
    assign sport_out = rec_data.ports_in ? rec_data.sport : 16'd0;
    assign dport_out = rec_data.ports_in ? rec_data.dport : 16'd0;

    // Take a record whenever the output register is free or being drained.
    assign load    = !rec_empty && (!valid_reg || out_ready);
    assign rec_pop = load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= 1'b1;
        else if (out_ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= {3'b000, dport_out, sport_out, rec_data.protocol, verdict,
                         verdict == hitf_pkg::VC_OK};
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

[hw/rtl/ipv4_tcp_udp_header_filter.sv]
// Top level of the IPv4 TCP/UDP header filter: configuration registers and the front/back pipeline.
//
// Frame bytes enter on the s_ stream, one byte per word, with s_tlast on the final byte.
// For every frame one verdict word leaves on the m_ stream after its last byte: accepted,
// the verdict code (first failing check), the IP protocol and the L4 ports.
// Configuration registers are written through cfg_wr_en / cfg_index / cfg_data; the user
// must write them only while the block is idle, which the block itself does not enforce.
// MAC and IP bytes are checked as they arrive, the rest at frame end. Throughput: one byte
// per cycle while s_tready is high, set by the byte parser. The accepting edge writes the record
// queue; the output register then takes the record, raising m_tvalid, once free or being drained.
// A four-entry record queue sits between parser and verdict stage, so the input keeps
// flowing while the receiver stalls until five verdicts are pending (four queued, one in
// the output register); then s_tready drops until m_tready takes one.
// Bytes at or past MAX_FRAME_BYTES are counted no further and not examined.
// Reset clears all configuration registers to zero, the parser state, the queue and
// the output valid flag; s_tready is high as soon as reset is released.
module ipv4_tcp_udp_header_filter #(
    parameter int unsigned MAX_FRAME_BYTES = hitf_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // [7:0] frame_byte
    input  logic        s_tlast,     // frame_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,     // [0] accepted, [4:1] verdict_code, [12:5] ip_protocol,
                                     // [28:13] source_port, [44:29] dest_port, [47:45] zero
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [47:0] cfg_data
);
    logic [3:0]  match_enables_reg;
    logic [47:0] want_src_mac_reg;
    logic [47:0] want_dst_mac_reg;
    logic [31:0] want_src_ip_reg;
    logic [31:0] want_dst_ip_reg;
    logic [7:0]  want_protocol_reg;
    logic [15:0] want_src_port_reg;
    logic [15:0] want_dst_port_reg;

    hitf_pkg::frame_rec_t push_rec;
    hitf_pkg::frame_rec_t head_rec;
    logic                 rec_push;
    logic                 rec_full;
    logic                 rec_pop;
    logic                 rec_empty;

    // Configuration register file.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_enables_reg <= '0;
            want_src_mac_reg  <= '0;
            want_dst_mac_reg  <= '0;
            want_src_ip_reg   <= '0;
            want_dst_ip_reg   <= '0;
            want_protocol_reg <= '0;
            want_src_port_reg <= '0;
            want_dst_port_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                hitf_pkg::REG_MATCH_ENABLES: match_enables_reg <= cfg_data[3:0];
                hitf_pkg::REG_SRC_MAC:       want_src_mac_reg  <= cfg_data;
                hitf_pkg::REG_DST_MAC:       want_dst_mac_reg  <= cfg_data;
                hitf_pkg::REG_SRC_IP:        want_src_ip_reg   <= cfg_data[31:0];
                hitf_pkg::REG_DST_IP:        want_dst_ip_reg   <= cfg_data[31:0];
                hitf_pkg::REG_PROTOCOL:      want_protocol_reg <= cfg_data[7:0];
                hitf_pkg::REG_SRC_PORT:      want_src_port_reg <= cfg_data[15:0];
                hitf_pkg::REG_DST_PORT:      want_dst_port_reg <= cfg_data[15:0];
                default:                     match_enables_reg <= match_enables_reg;
            endcase
        end
    end

    // Front end: byte parser.
    hitf_parser #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_byte      (s_tdata),
        .in_last      (s_tlast),
        .want_src_mac (want_src_mac_reg),
        .want_dst_mac (want_dst_mac_reg),
        .want_src_ip  (want_src_ip_reg),
        .want_dst_ip  (want_dst_ip_reg),
        .rec_push     (rec_push),
        .rec_data     (push_rec),
        .rec_full     (rec_full)
    );

    // Record queue.
    hitf_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (rec_push),
        .push_data (push_rec),
        .full      (rec_full),
        .pop       (rec_pop),
        .pop_data  (head_rec),
        .empty     (rec_empty)
    );

    // Back end: verdict and output register.
    hitf_verdict u_verdict (
        .clk           (clk),
        .rst_n         (rst_n),
        .rec_empty     (rec_empty),
        .rec_data      (head_rec),
        .rec_pop       (rec_pop),
        .match_enables (match_enables_reg),
        .want_protocol (want_protocol_reg),
        .want_src_port (want_src_port_reg),
        .want_dst_port (want_dst_port_reg),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_data      (m_tdata)
    );

endmodule

[tb/tb_ipv4_tcp_udp_header_filter.sv]
// Self-checking testbench for the IPv4 TCP/UDP header filter: frame stimulus, verdict predictor and output checker.
`timescale 1ns / 1ps

module tb_ipv4_tcp_udp_header_filter;

    localparam int unsigned FRAME_LIMIT       = hitf_pkg::MAX_FRAME_BYTES_DEF;
    localparam int unsigned RANDOM_BYTES      = 930;
    localparam int unsigned MIN_RANDOM_FRAMES = 20;
    localparam int unsigned FRAMES_PER_FILTER = 12;
    localparam int unsigned IDLE_LIMIT        = 2000;

    // One complete set of filter registers.
    typedef struct {
        logic [3:0]  enables;
        logic [47:0] src_mac;
        logic [47:0] dst_mac;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [7:0]  protocol;
        logic [15:0] sport;
        logic [15:0] dport;
    } filter_t;

    // Fields of one verdict word.
    typedef struct packed {
        logic               accepted;
        hitf_pkg::verdict_t code;
        logic [7:0]         protocol;
        logic [15:0]        sport;
        logic [15:0]        dport;
    } verdict_word_t;

    // Ways in which a generated frame departs from one the filter accepts.
    typedef enum int {
        FLAW_NONE,
        FLAW_ETYPE,
        FLAW_SRC_MAC,
        FLAW_DST_MAC,
        FLAW_IP,
        FLAW_PROTO,
        FLAW_NOT_L4,
        FLAW_PORT,
        FLAW_NOISE
    } flaw_t;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;     // [7:0] frame_byte
    logic        s_tlast   = 1'b0;   // frame_end
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [47:0] m_tdata;            // [0] accepted, [4:1] verdict_code, [12:5] ip_protocol,
                                     // [28:13] source_port, [44:29] dest_port
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [47:0] cfg_data  = '0;

    ipv4_tcp_udp_header_filter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predictor copy of the filter registers and the per-frame parse state.
    filter_t       filt;
    int unsigned   fr_pos   = 0;
    logic [3:0]    fr_ihl   = '0;
    logic [15:0]   fr_etype = '0;
    logic [7:0]    fr_proto = '0;
    logic [15:0]   fr_sport = '0;
    logic [15:0]   fr_dport = '0;
    logic [3:0]    fr_mism  = '0;
    verdict_word_t verdicts_due[$];

    // Run bookkeeping.
    int unsigned bytes_sent      = 0;
    int unsigned frames_sent     = 0;
    int unsigned verdicts_seen   = 0;
    int unsigned filter_settings = 0;
    int unsigned mismatches      = 0;
    int unsigned code_seen[9];
    int unsigned idle_cycles     = 0;

    // Sender burst control.
    int unsigned burst_left  = 0;
    bit          steady_send = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Verdict prediction: one frame byte at a time, one verdict word on the last byte.
    task automatic predict_byte(input logic [7:0] b, input logic last);
        int unsigned        p;
        int unsigned        hw;
        int unsigned        ps;
        int unsigned        port_end;
        logic               ports_in;
        hitf_pkg::verdict_t vc;
        verdict_word_t      w;
        begin
            if (fr_pos < FRAME_LIMIT)
            begin
                p = fr_pos;
                if (p < hitf_pkg::OFS_SRC_MAC)
                begin
                    if (filt.dst_mac[8 * (5 - p) +: 8] != b)
                        fr_mism[hitf_pkg::BIT_DST_MAC] = 1'b1;
                end
                else if (p < hitf_pkg::OFS_ETYPE)
                begin
                    if (filt.src_mac[8 * (11 - p) +: 8] != b)
                        fr_mism[hitf_pkg::BIT_SRC_MAC] = 1'b1;
                end
                else if (p < hitf_pkg::OFS_IHL)
                    fr_etype = {fr_etype[7:0], b};
                if (p == hitf_pkg::OFS_IHL)
                    fr_ihl = b[3:0];
                if (p == hitf_pkg::OFS_PROTOCOL)
                    fr_proto = b;
                if (p >= hitf_pkg::OFS_SRC_IP && p < hitf_pkg::OFS_DST_IP
                    && filt.src_ip[8 * (29 - p) +: 8] != b)
                    fr_mism[hitf_pkg::BIT_SRC_IP] = 1'b1;
                if (p >= hitf_pkg::OFS_DST_IP && p < hitf_pkg::OFS_IP_END
                    && filt.dst_ip[8 * (33 - p) +: 8] != b)
                    fr_mism[hitf_pkg::BIT_DST_IP] = 1'b1;

                // The port offset follows the IHL nibble, even on the byte that carries it.
                hw = (p == hitf_pkg::OFS_IHL) ? {28'd0, b[3:0]} : {28'd0, fr_ihl};
                ps = hitf_pkg::OFS_IHL + 4 * hw;
                if (p >= hitf_pkg::OFS_IHL)
                begin
                    if (p >= ps && p < ps + 2)
                        fr_sport = {fr_sport[7:0], b};
                    else if (p >= ps + 2 && p < ps + 4)
                        fr_dport = {fr_dport[7:0], b};
                end
                fr_pos = fr_pos + 1;
            end

            if (last)
            begin
                port_end = hitf_pkg::OFS_IHL + 4 * {28'd0, fr_ihl} + 4;
                ports_in = (fr_pos >= hitf_pkg::MIN_PORT_BYTES) && (fr_pos >= port_end);

                // The first failing check decides the verdict.
                if (fr_pos < hitf_pkg::OFS_IHL)
                    vc = hitf_pkg::VC_TRUNCATED;
                else if (fr_etype != hitf_pkg::ETHERTYPE_IPV4)
                    vc = hitf_pkg::VC_NOT_IPV4;
                else if (filt.enables[hitf_pkg::BIT_SRC_MAC] && fr_mism[hitf_pkg::BIT_SRC_MAC])
                    vc = hitf_pkg::VC_SRC_MAC;
                else if (filt.enables[hitf_pkg::BIT_DST_MAC] && fr_mism[hitf_pkg::BIT_DST_MAC])
                    vc = hitf_pkg::VC_DST_MAC;
                else if (fr_pos < hitf_pkg::OFS_IP_END)
                    vc = hitf_pkg::VC_TRUNCATED;
                else if ((filt.enables & fr_mism & 4'b1100) != 4'b0000)
                    vc = hitf_pkg::VC_IP;
                else if (filt.protocol != 8'd0 && filt.protocol != fr_proto)
                    vc = hitf_pkg::VC_PROTOCOL;
                else if (fr_proto != hitf_pkg::PROTO_TCP && fr_proto != hitf_pkg::PROTO_UDP)
                    vc = hitf_pkg::VC_NOT_L4;
                else if (!ports_in)
                    vc = hitf_pkg::VC_TRUNCATED;
                else if ((filt.sport != 16'd0 && filt.sport != fr_sport) ||
                         (filt.dport != 16'd0 && filt.dport != fr_dport))
                    vc = hitf_pkg::VC_PORT;
                else
                    vc = hitf_pkg::VC_OK;

                w.accepted = (vc == hitf_pkg::VC_OK);
                w.code     = vc;
                w.protocol = fr_proto;
                w.sport    = ports_in ? fr_sport : 16'd0;
                w.dport    = ports_in ? fr_dport : 16'd0;
                verdicts_due.push_back(w);

                fr_pos   = 0;
                fr_ihl   = '0;
                fr_etype = '0;
                fr_proto = '0;
                fr_sport = '0;
                fr_dport = '0;
                fr_mism  = '0;
            end
        end
    endtask

    task automatic report_mismatch(input string field, input logic [15:0] got,
                                   input logic [15:0] want);
        begin
            $display("Mismatch on verdict %0d: %s is %0h, predicted %0h",
                     verdicts_seen, field, got, want);
            mismatches++;
        end
    endtask

    // Send one frame byte; gaps fall between random-length bursts unless sending steadily.
    task automatic send_word(input logic [7:0] b, input logic last);
        int unsigned gap;
        begin
            if (!steady_send && burst_left == 0)
            begin
                gap        = $urandom_range(1, 6);
                burst_left = $urandom_range(1, 24);
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            if (burst_left > 0)
                burst_left--;
            s_tvalid <= 1'b1;
            s_tdata  <= b;
            s_tlast  <= last;
            @(posedge clk);
            while (!s_tready)
                @(posedge clk);
            predict_byte(b, last);
            bytes_sent++;
        end
    endtask

    // Wait until every predicted verdict has come out and the pipeline is empty.
    task automatic drain_verdicts();
        begin
            s_tvalid <= 1'b0;
            while (verdicts_due.size() != 0)
                @(posedge clk);
            repeat (4) @(posedge clk);
        end
    endtask

    task automatic put_reg(input logic [2:0] idx, input logic [47:0] value);
        begin
            cfg_wr_en <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= value;
            @(posedge clk);
        end
    endtask

    // Write all eight filter registers; only called while the block is idle.
    task automatic apply_filter(input filter_t f);
        begin
            put_reg(hitf_pkg::REG_MATCH_ENABLES, {44'd0, f.enables});
            put_reg(hitf_pkg::REG_SRC_MAC, f.src_mac);
            put_reg(hitf_pkg::REG_DST_MAC, f.dst_mac);
            put_reg(hitf_pkg::REG_SRC_IP, {16'd0, f.src_ip});
            put_reg(hitf_pkg::REG_DST_IP, {16'd0, f.dst_ip});
            put_reg(hitf_pkg::REG_PROTOCOL, {40'd0, f.protocol});
            put_reg(hitf_pkg::REG_SRC_PORT, {32'd0, f.sport});
            put_reg(hitf_pkg::REG_DST_PORT, {32'd0, f.dport});
            cfg_wr_en <= 1'b0;
            filt = f;
            filter_settings++;
        end
    endtask

    function automatic logic [47:0] rand48();
        logic [63:0] t;
        begin
            t = {$urandom, $urandom};
            return t[47:0];
        end
    endfunction

    // Build a frame that the current filter would accept, spoil it as asked, cut it
    // (cut > 0 keeps that many bytes, cut < 0 picks a random length) and send it.
    task automatic send_frame(input flaw_t flaw, input int unsigned ihl,
                              input int unsigned tail, input int cut);
        logic [7:0]  f[$];
        logic [15:0] sport;
        logic [15:0] dport;
        logic [7:0]  v;
        int unsigned ps;
        int unsigned len;
        int unsigned keep;
        begin
            f = {};
            for (int i = 0; i < 6; i++)
                f.push_back(filt.dst_mac[8 * (5 - i) +: 8]);
            for (int i = 0; i < 6; i++)
                f.push_back(filt.src_mac[8 * (5 - i) +: 8]);
            f.push_back(hitf_pkg::ETHERTYPE_IPV4[15:8]);
            f.push_back(hitf_pkg::ETHERTYPE_IPV4[7:0]);
            f.push_back({4'h4, ihl[3:0]});
            for (int i = 15; i < hitf_pkg::OFS_PROTOCOL; i++)
                f.push_back(8'($urandom_range(0, 255)));
            if (filt.protocol != 8'd0)
                f.push_back(filt.protocol);
            else
                f.push_back($urandom_range(0, 1) ? hitf_pkg::PROTO_TCP : hitf_pkg::PROTO_UDP);
            f.push_back(8'($urandom_range(0, 255)));
            f.push_back(8'($urandom_range(0, 255)));
            for (int i = 0; i < 4; i++)
                f.push_back(filt.src_ip[8 * (3 - i) +: 8]);
            for (int i = 0; i < 4; i++)
                f.push_back(filt.dst_ip[8 * (3 - i) +: 8]);

            // Options, ports and payload.
            ps  = hitf_pkg::OFS_IHL + 4 * ihl;
            len = ((ps + 4 > hitf_pkg::OFS_IP_END) ? ps + 4 : hitf_pkg::OFS_IP_END) + tail;
            while (f.size() < len)
                f.push_back(8'($urandom_range(0, 255)));
            sport = (filt.sport != 16'd0) ? filt.sport : 16'($urandom);
            dport = (filt.dport != 16'd0) ? filt.dport : 16'($urandom);
            // A short header puts the ports over IP fields; those bytes keep their header values.
            if (ihl >= 5)
            begin
                f[ps]     = sport[15:8];
                f[ps + 1] = sport[7:0];
                f[ps + 2] = dport[15:8];
                f[ps + 3] = dport[7:0];
            end

            case (flaw)
                FLAW_ETYPE:
                    f[hitf_pkg::OFS_ETYPE + $urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
                FLAW_SRC_MAC:
                    f[hitf_pkg::OFS_SRC_MAC + $urandom_range(0, 5)] ^= 8'($urandom_range(1, 255));
                FLAW_DST_MAC:
                    f[$urandom_range(0, 5)] ^= 8'($urandom_range(1, 255));
                FLAW_IP:
                    f[hitf_pkg::OFS_SRC_IP + $urandom_range(0, 7)] ^= 8'($urandom_range(1, 255));
                FLAW_PROTO:
                    f[hitf_pkg::OFS_PROTOCOL] ^= 8'($urandom_range(1, 255));
                FLAW_NOT_L4:
                begin
                    do
                        v = 8'($urandom_range(0, 255));
                    while (v == hitf_pkg::PROTO_TCP || v == hitf_pkg::PROTO_UDP);
                    f[hitf_pkg::OFS_PROTOCOL] = v;
                end
                FLAW_PORT:
                begin
                    if (ihl >= 5)
                        f[ps + $urandom_range(0, 3)] ^= 8'($urandom_range(1, 255));
                end
                FLAW_NOISE:
                begin
                    f   = {};
                    len = $urandom_range(1, 60);
                    repeat (len) f.push_back(8'($urandom_range(0, 255)));
                end
                default: ;
            endcase

            if (cut != 0)
            begin
                keep = (cut > 0) ? cut : $urandom_range(1, (f.size() > 1) ? f.size() - 1 : 1);
                while (f.size() > keep)
                    void'(f.pop_back());
            end

            for (int i = 0; i < f.size(); i++)
                send_word(f[i], i == f.size() - 1);
            frames_sent++;
        end
    endtask

    // Receiver: always ready, a repeating stall pattern, or sparse acceptance.
    logic [15:0] ready_pat = 16'hA5C3;
    int unsigned rx_mode   = 0;
    int unsigned rx_tick   = 0;

    always @(posedge clk)
    begin
        if (rx_tick % 97 == 0)
        begin
            rx_mode   = $urandom_range(0, 2);
            ready_pat = 16'($urandom_range(1, 65535));
        end
        rx_tick++;
        case (rx_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ready_pat[rx_tick % 16];
            default: m_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // Compare each verdict word with the oldest prediction.
    always @(posedge clk)
    begin : check_verdicts
        verdict_word_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (verdicts_due.size() == 0)
            begin
                $display("Verdict word %0h arrived with no frame outstanding", m_tdata);
                mismatches++;
            end
            else
            begin
                want = verdicts_due.pop_front();
                code_seen[want.code]++;
                if (m_tdata[0] !== want.accepted)
                    report_mismatch("accepted", {15'd0, m_tdata[0]}, {15'd0, want.accepted});
                if (m_tdata[4:1] !== want.code)
                    report_mismatch("verdict_code", {12'd0, m_tdata[4:1]}, {12'd0, want.code});
                if (m_tdata[12:5] !== want.protocol)
                    report_mismatch("ip_protocol", {8'd0, m_tdata[12:5]}, {8'd0, want.protocol});
                if (m_tdata[28:13] !== want.sport)
                    report_mismatch("source_port", m_tdata[28:13], want.sport);
                if (m_tdata[44:29] !== want.dport)
                    report_mismatch("dest_port", m_tdata[44:29], want.dport);
            end
            verdicts_seen++;
        end
    end

    // Watchdog on cycles in which no word moves and no register is written.
    always @(posedge clk)
    begin
        if (!rst_n || cfg_wr_en || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Watchdog: nothing moved for %0d cycles, %0d verdicts outstanding",
                     IDLE_LIMIT, verdicts_due.size());
            $display("FAIL");
            $finish;
        end
    end

    // Reset defaults: all filters off, so short frames, wrong EtherType, odd header
    // lengths and non-TCP/UDP protocols decide the verdict.
    task automatic test_reset_defaults();
        begin
            send_frame(FLAW_NONE, 5, 0, 0);
            send_frame(FLAW_NONE, 5, 3, 1);
            send_frame(FLAW_NONE, 5, 0, 13);
            send_frame(FLAW_NONE, 5, 0, 14);
            send_frame(FLAW_ETYPE, 5, 2, 0);
            send_frame(FLAW_NONE, 5, 0, 33);
            send_frame(FLAW_NONE, 5, 0, 36);
            send_frame(FLAW_NONE, 15, 0, 0);
            send_frame(FLAW_NONE, 0, 0, 0);
            send_frame(FLAW_NONE, 2, 1, 0);
            send_frame(FLAW_NOT_L4, 5, 0, 0);
            drain_verdicts();
        end
    endtask

    // Every register at its maximum: the MAC, IP and protocol checks in turn.
    task automatic test_all_ones_filter();
        filter_t f;
        begin
            f.enables  = 4'hF;
            f.src_mac  = '1;
            f.dst_mac  = '1;
            f.src_ip   = '1;
            f.dst_ip   = '1;
            f.protocol = 8'hFF;
            f.sport    = 16'hFFFF;
            f.dport    = 16'hFFFF;
            apply_filter(f);
            send_frame(FLAW_NONE, 5, 0, 0);
            send_frame(FLAW_SRC_MAC, 5, 0, 0);
            send_frame(FLAW_DST_MAC, 5, 0, 0);
            send_frame(FLAW_IP, 5, 0, 0);
            send_frame(FLAW_PROTO, 5, 0, 0);
            drain_verdicts();
        end
    endtask

    // Exact five-tuple match on TCP: accept, port miss, a frame ending in the ports, and options.
    task automatic test_exact_match();
        filter_t f;
        begin
            f.enables  = 4'hF;
            f.src_mac  = rand48();
            f.dst_mac  = rand48();
            f.src_ip   = $urandom;
            f.dst_ip   = $urandom;
            f.protocol = hitf_pkg::PROTO_TCP;
            f.sport    = 16'($urandom_range(1, 65535));
            f.dport    = 16'($urandom_range(1, 65535));
            apply_filter(f);
            send_frame(FLAW_NONE, 5, 4, 0);
            send_frame(FLAW_PORT, 5, 0, 0);
            send_frame(FLAW_NONE, 5, 0, 36);
            send_frame(FLAW_NONE, 7, 2, 0);
        end
    endtask

    // Mostly well-formed frames under changing filters, with flaws, cuts and noise.
    task automatic test_random_traffic();
        filter_t     f;
        int unsigned start_bytes;
        int unsigned n;
        int unsigned r;
        int unsigned ihl;
        flaw_t       flaw;
        begin
            start_bytes = bytes_sent;
            n = 0;
            while (bytes_sent - start_bytes < RANDOM_BYTES || n < MIN_RANDOM_FRAMES)
            begin
                if (n % FRAMES_PER_FILTER == 0)
                begin
                    drain_verdicts();
                    f.enables = 4'($urandom_range(0, 15));
                    f.src_mac = rand48();
                    f.dst_mac = rand48();
                    f.src_ip  = $urandom;
                    f.dst_ip  = $urandom;
                    case ($urandom_range(0, 3))
                        0:       f.protocol = 8'd0;
                        1:       f.protocol = hitf_pkg::PROTO_TCP;
                        2:       f.protocol = hitf_pkg::PROTO_UDP;
                        default: f.protocol = 8'($urandom_range(0, 255));
                    endcase
                    f.sport = $urandom_range(0, 1) ? 16'd0 : 16'($urandom);
                    f.dport = $urandom_range(0, 1) ? 16'd0 : 16'($urandom);
                    apply_filter(f);
                    steady_send = ($urandom_range(0, 3) == 0);
                end

                r    = $urandom_range(0, 99);
                flaw = (r < 45) ? FLAW_NONE : flaw_t'($urandom_range(FLAW_ETYPE, FLAW_NOISE));
                r    = $urandom_range(0, 99);
                if (r < 70)
                    ihl = 5;
                else if (r < 85)
                    ihl = $urandom_range(6, 15);
                else
                    ihl = $urandom_range(0, 4);
                send_frame(flaw, ihl, $urandom_range(0, 10),
                           ($urandom_range(0, 99) < 15) ? -1 : 0);
                n++;
            end
            steady_send = 1'b0;
        end
    endtask

    initial
    begin
        filt = '{default: '0};
        foreach (code_seen[i])
            code_seen[i] = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_all_ones_filter();
        test_exact_match();
        test_random_traffic();

        drain_verdicts();
        repeat (8) @(posedge clk);

        $display("Run covered %0d frames (%0d bytes) under %0d filter settings, %0d verdicts.",
                 frames_sent, bytes_sent, filter_settings, verdicts_seen);
        $display("Verdicts by code 0..8: %0d %0d %0d %0d %0d %0d %0d %0d %0d",
                 code_seen[0], code_seen[1], code_seen[2], code_seen[3], code_seen[4],
                 code_seen[5], code_seen[6], code_seen[7], code_seen[8]);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
